// File: hdl/qwt_pkg.sv
// Package: shared types and constants of the quoted word tokenizer.
package qwt_pkg;

	localparam logic [6:0] MAX_WORDS    = 7'd64;
	localparam logic [6:0] LEN_MAX      = 7'd95;  // word bytes kept per word, at most
	localparam logic [6:0] LIMIT_RESET  = 7'd64;
	localparam int unsigned RESULT_DEPTH = 4;

	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;

	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,
		KIND_END  = 2'd1,
		KIND_DONE = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_TOO_MANY  = 2'd1,
		ST_UNMATCHED = 2'd2
	} status_t;

	typedef enum logic {
		MODE_DATA = 1'b0,
		MODE_EOI  = 1'b1
	} mode_t;

	typedef struct packed {
		kind_t       kind;
		logic [5:0]  word_index;
		logic [6:0]  position;
		logic [7:0]  out_byte;
		logic [6:0]  word_length;
		status_t     status;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [1:0] count;  // 0, 1 or 2 results
		result_t    first;
		result_t    second;
	} core_out_t;

endpackage

// File: hdl/qwt_core.sv
// Tokenizer state and per-byte decision logic.
module qwt_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  logic                mode,
	input  logic [7:0]          in_byte,
	input  logic [6:0]          word_limit,
	output qwt_pkg::core_out_t  res
);

	logic       quoting_q;
	logic       dbl_q;
	logic [6:0] len_q;
	logic [6:0] words_q;
	logic       ovf_q;

	logic       quoting_d;
	logic       dbl_d;
	logic [6:0] len_d;
	logic [6:0] words_d;
	logic       ovf_d;

	logic [6:0] lim;
	logic       excess;
	logic       is_ws;
	logic       is_quote;
	logic [7:0] close_q;

	qwt_pkg::result_t blank;

	always_comb begin
		lim      = (word_limit > qwt_pkg::MAX_WORDS) ? qwt_pkg::MAX_WORDS : word_limit;
		excess   = (words_q >= lim);
		is_ws    = (in_byte == qwt_pkg::CH_SPACE) || (in_byte == qwt_pkg::CH_TAB) ||
		           (in_byte == qwt_pkg::CH_CR) || (in_byte == qwt_pkg::CH_LF);
		is_quote = (in_byte == qwt_pkg::CH_SQUOTE) || (in_byte == qwt_pkg::CH_DQUOTE);
		close_q  = dbl_q ? qwt_pkg::CH_DQUOTE : qwt_pkg::CH_SQUOTE;

		blank             = '0;
		blank.kind        = qwt_pkg::KIND_BYTE;
		blank.status      = qwt_pkg::ST_OK;
		blank.last        = 1'b1;

		quoting_d = quoting_q;
		dbl_d     = dbl_q;
		len_d     = len_q;
		words_d   = words_q;
		ovf_d     = ovf_q;

		res        = '0;
		res.first  = blank;
		res.second = blank;

		if (mode == qwt_pkg::MODE_EOI) begin
			res.second.kind = qwt_pkg::KIND_DONE;
			if (ovf_q) begin
				res.second.status = qwt_pkg::ST_TOO_MANY;
			end else if (quoting_q) begin
				res.second.status = qwt_pkg::ST_UNMATCHED;
			end else if ((len_q != 7'd0) && excess) begin
				res.second.status = qwt_pkg::ST_TOO_MANY;
			end else begin
				res.second.status = qwt_pkg::ST_OK;
			end
			if (!ovf_q && !quoting_q && !excess && (len_q != 7'd0)) begin
				res.count             = 2'd2;
				res.first.kind        = qwt_pkg::KIND_END;
				res.first.word_index  = words_q[5:0];
				res.first.word_length = len_q;
				res.first.last        = 1'b0;
			end else begin
				res.count = 2'd1;
				res.first = res.second;
			end
			quoting_d = 1'b0;
			dbl_d     = 1'b0;
			len_d     = '0;
			words_d   = '0;
			ovf_d     = 1'b0;
		end else if (!ovf_q) begin
			if (quoting_q && (in_byte == close_q)) begin
				quoting_d = 1'b0;
			end else if (!quoting_q && is_quote) begin
				quoting_d = 1'b1;
				dbl_d     = (in_byte == qwt_pkg::CH_DQUOTE);
			end else if (!quoting_q && is_ws) begin
				if (len_q != 7'd0) begin
					len_d = '0;
					if (excess) begin
						ovf_d = 1'b1;
					end else begin
						res.count             = 2'd1;
						res.first.kind        = qwt_pkg::KIND_END;
						res.first.word_index  = words_q[5:0];
						res.first.word_length = len_q;
						words_d               = words_q + 7'd1;
					end
				end
			end else if (len_q < qwt_pkg::LEN_MAX) begin
				len_d = len_q + 7'd1;
				if (!excess) begin
					res.count            = 2'd1;
					res.first.kind       = qwt_pkg::KIND_BYTE;
					res.first.word_index = words_q[5:0];
					res.first.position   = len_q;
					res.first.out_byte   = in_byte;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quoting_q <= 1'b0;
			dbl_q     <= 1'b0;
			len_q     <= '0;
			words_q   <= '0;
			ovf_q     <= 1'b0;
		end else if (go) begin
			quoting_q <= quoting_d;
			dbl_q     <= dbl_d;
			len_q     <= len_d;
			words_q   <= words_d;
			ovf_q     <= ovf_d;
		end
	end

endmodule

// File: hdl/qwt_outq.sv
// Small result queue: takes up to two results per cycle, gives one when out_ready is high.
module qwt_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  qwt_pkg::core_out_t  res,
	output logic                room2,
	output logic                out_valid,
	input  logic                out_ready,
	output qwt_pkg::result_t    out_res
);

	localparam int unsigned AW = $clog2(qwt_pkg::RESULT_DEPTH);

	qwt_pkg::result_t entry_q [qwt_pkg::RESULT_DEPTH];
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [AW:0]      cnt_q;
	logic [1:0]       n_in;
	logic             pop;

	always_comb begin
		n_in      = push ? res.count : 2'd0;
		out_valid = (cnt_q != '0);
		pop       = out_valid && out_ready;
		out_res   = entry_q[rd_q];
		room2     = (cnt_q <= (AW+1)'(qwt_pkg::RESULT_DEPTH - 2));
	end

	always_ff @(posedge clk) begin
		if (n_in != 2'd0) begin
			entry_q[wr_q] <= res.first;
		end
		if (n_in == 2'd2) begin
			entry_q[wr_q + AW'(1)] <= res.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + AW'(n_in);
			rd_q  <= rd_q + AW'(pop);
			cnt_q <= cnt_q + (AW+1)'(n_in) - (AW+1)'(pop);
		end
	end

endmodule

// File: hdl/quoted_word_tokenizer.sv
// Top level: quoted word tokenizer with input register, core and result queue.
//
//   channel  | dir | tdata                                        | tuser | tlast
//   s_*      | in  | in_byte[7:0]                                 | mode  | -
//   m_*      | out | word_index, position, out_byte, word_length, | kind  | last
//            |     | status (low bits up), zero pad to 32         |       |
//   cfg_*    | in  | word_limit[6:0] in cfg_data                  | -     | -
//
// One input byte per cycle while s_tready is high. An end-of-input transfer that closes
// a word gives two results, which leave the output port one after the other; the result queue
// absorbs the second, and s_tready drops when the queue has no room for two results.
// An input transfer passes through the input register, the core and the result queue.
// arst_n clears the control state but not the data registers; word_limit returns to 64.
// Output stalls back up through the four-entry result queue into s_tready.
module quoted_word_tokenizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tuser,   // [0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [5:0] word_index, [12:6] position, [20:13] out_byte,
	                               // [27:21] word_length, [29:28] status, [31:30] zero
	output logic [1:0]  m_tuser,   // [1:0] kind
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data
);

	logic       valid_s1;
	logic       mode_s1;
	logic [7:0] byte_s1;
	logic [6:0] word_limit_q;
	logic       go;
	logic       room2;

	qwt_pkg::core_out_t core_res;
	qwt_pkg::result_t   out_res;

	assign cfg_ready = 1'b1;
	assign go        = valid_s1 && room2;
	assign s_tready  = !valid_s1 || room2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			word_limit_q <= qwt_pkg::LIMIT_RESET;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (cfg_valid) begin
				word_limit_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_s1 <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	qwt_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (go),
		.mode       (mode_s1),
		.in_byte    (byte_s1),
		.word_limit (word_limit_q),
		.res        (core_res)
	);

	qwt_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (go),
		.res       (core_res),
		.room2     (room2),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = {2'b00, out_res.status, out_res.word_length, out_res.out_byte,
	                  out_res.position, out_res.word_index};
	assign m_tuser = out_res.kind;
	assign m_tlast = out_res.last;

endmodule
